/* sv/assert_macros.svh */
// Assertion macros used by cct_checker.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CCT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define CCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/cct_pkg.sv */
// Shared types, constants and pin table of the capacitive conductivity timer.
// Depends on nothing; used by cct_seq and the top level.
package cct_pkg;

  localparam int TIMER_BITS = 16;
  localparam int MAX_RATE   = 10;
  localparam int ACC_BITS   = TIMER_BITS + MAX_RATE;
  localparam int CYC_BITS   = MAX_RATE + 1;
  localparam int RATE_W     = 4;
  localparam int LIM_W      = 16;
  localparam int READ_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CMP_W      = 33;

  localparam logic [TIMER_BITS-1:0] TMAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE       = 3'd0,
    ST_CHARGE_POS = 3'd1,
    ST_MEASURE    = 3'd2,
    ST_DISCHARGE  = 3'd3,
    ST_CHARGE_NEG = 3'd4,
    ST_COMPENSATE = 3'd5,
    ST_RECHARGE   = 3'd6
  } stage_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RATE      = 3'd0,
    REG_CHARGE    = 3'd1,
    REG_DISCHARGE = 3'd2,
    REG_TIMEOUT   = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [RATE_W-1:0] oversample_rate;
    logic [LIM_W-1:0]  charge_ticks;
    logic [LIM_W-1:0]  discharge_ticks;
    logic [LIM_W-1:0]  timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic pos_drive;
    logic pos_high;
    logic neg_drive;
    logic neg_high;
    logic probe_drive;
    logic probe_high;
  } pins_t;

  typedef struct packed {
    pins_t             pins;
    logic              busy;
    logic              done;
    logic [READ_W-1:0] reading;
    logic              failed;
  } res_t;

  function automatic pins_t stage_pins(stage_t s);
    pins_t p;
    p = '0;
    unique case (s)
      ST_CHARGE_POS: p = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0};
      ST_MEASURE:    p = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
      ST_DISCHARGE:  p = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
      ST_CHARGE_NEG: p = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
      ST_COMPENSATE: p = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
      ST_RECHARGE:   p = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
      default:       p = '0;
    endcase
    return p;
  endfunction

endpackage

/* sv/cct_seq.sv */
// Stage sequencer: stage timer, cycle counter, accumulator and held reading.
// Depends on cct_pkg; advances one measurement tick per step.
module cct_seq
  import cct_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic step,
  input  logic start,
  input  logic pin,
  input  cfg_t cfg,
  output res_t res
);

  stage_t                stage_r, stage_nxt;
  logic [TIMER_BITS-1:0] ticks_r, ticks_nxt, ticks_inc;
  logic [CYC_BITS-1:0]   cyc_r, cyc_nxt, cyc_inc, cyc_target;
  logic [ACC_BITS-1:0]   acc_r, acc_nxt;
  logic [LIM_W-1:0]      last_r, last_nxt, limit;
  logic                  pin_before_r;
  logic [READ_W-1:0]     held_r, held_nxt;
  logic                  fail_r, fail_nxt;
  logic                  done_nxt;
  logic [RATE_W-1:0]     rate;
  logic                  reached;
  logic                  edge_seen;

  assign rate = (cfg.oversample_rate > RATE_W'(MAX_RATE)) ? RATE_W'(MAX_RATE)
                                                          : cfg.oversample_rate;
  assign ticks_inc  = (ticks_r != TMAX) ? ticks_r + 1'b1 : ticks_r;
  assign cyc_inc    = cyc_r + 1'b1;
  assign cyc_target = CYC_BITS'(1) << rate;
  assign edge_seen  = pin_before_r & ~pin;

  always_comb begin
    unique case (stage_r) inside
      ST_CHARGE_POS, ST_CHARGE_NEG: limit = cfg.charge_ticks;
      ST_MEASURE:                   limit = cfg.timeout_ticks;
      ST_DISCHARGE, ST_RECHARGE:    limit = cfg.discharge_ticks;
      ST_COMPENSATE:                limit = last_r;
      default:                      limit = cfg.charge_ticks;
    endcase
  end

  assign reached = (CMP_W'(ticks_inc) >= CMP_W'(limit)) || (ticks_inc == TMAX);

  always_comb begin
    stage_nxt = stage_r;
    ticks_nxt = ticks_r;
    cyc_nxt   = cyc_r;
    acc_nxt   = acc_r;
    last_nxt  = last_r;
    held_nxt  = held_r;
    fail_nxt  = fail_r;
    done_nxt  = 1'b0;
    unique case (stage_r)
      ST_IDLE: begin
        if (start) begin
          cyc_nxt   = '0;
          acc_nxt   = '0;
          stage_nxt = ST_CHARGE_POS;
          ticks_nxt = '0;
        end
      end
      ST_CHARGE_POS: begin
        ticks_nxt = ticks_inc;
        if (reached) begin
          stage_nxt = ST_MEASURE;
          ticks_nxt = '0;
        end
      end
      ST_MEASURE: begin
        ticks_nxt = ticks_inc;
        if (edge_seen) begin
          last_nxt  = LIM_W'(ticks_inc);
          acc_nxt   = acc_r + ACC_BITS'(ticks_inc);
          stage_nxt = ST_DISCHARGE;
          ticks_nxt = '0;
        end else if (reached) begin
          held_nxt  = '0;
          fail_nxt  = 1'b1;
          done_nxt  = 1'b1;
          stage_nxt = ST_IDLE;
          ticks_nxt = '0;
        end
      end
      ST_DISCHARGE: begin
        ticks_nxt = ticks_inc;
        if (reached) begin
          stage_nxt = ST_CHARGE_NEG;
          ticks_nxt = '0;
        end
      end
      ST_CHARGE_NEG: begin
        ticks_nxt = ticks_inc;
        if (reached) begin
          stage_nxt = ST_COMPENSATE;
          ticks_nxt = '0;
        end
      end
      ST_COMPENSATE: begin
        ticks_nxt = ticks_inc;
        if (reached) begin
          stage_nxt = ST_RECHARGE;
          ticks_nxt = '0;
        end
      end
      ST_RECHARGE: begin
        ticks_nxt = ticks_inc;
        if (reached) begin
          cyc_nxt   = cyc_inc;
          ticks_nxt = '0;
          if (cyc_inc >= cyc_target) begin
            held_nxt  = READ_W'(acc_r >> rate);
            fail_nxt  = 1'b0;
            done_nxt  = 1'b1;
            stage_nxt = ST_IDLE;
          end else begin
            stage_nxt = ST_CHARGE_POS;
          end
        end
      end
      default: begin
        stage_nxt = ST_IDLE;
        ticks_nxt = '0;
      end
    endcase
  end

  always_comb begin
    res.pins    = stage_pins(stage_nxt);
    res.busy    = (stage_nxt != ST_IDLE);
    res.done    = done_nxt;
    res.reading = held_nxt;
    res.failed  = fail_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r      <= ST_IDLE;
      ticks_r      <= '0;
      cyc_r        <= '0;
      acc_r        <= '0;
      last_r       <= '0;
      pin_before_r <= 1'b0;
      held_r       <= '0;
      fail_r       <= 1'b0;
    end else if (step) begin
      stage_r      <= stage_nxt;
      ticks_r      <= ticks_nxt;
      cyc_r        <= cyc_nxt;
      acc_r        <= acc_nxt;
      last_r       <= last_nxt;
      pin_before_r <= pin;
      held_r       <= held_nxt;
      fail_r       <= fail_nxt;
    end
  end

endmodule

/* sv/capacitive_conductivity_timer.sv */
// Capacitive conductivity timer: takes one measurement tick per transaction and
// returns one result per tick. Depends on cct_pkg and cct_seq.
//
// Each input transaction is one timer tick. It is held in the input register;
// when the output register is free to take a result, the stage sequencer updates
// its state and the result is captured in the output register. A new tick is
// accepted in every cycle while the result side keeps up. A reading lasts
// 2^oversample_rate six-stage cycles of ticks, with the rate capped at 10, or
// ends early on a timeout; done_res marks the tick on which it completes. The
// configuration port is always ready; write it only while no reading is in
// progress.
module capacitive_conductivity_timer
  import cct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_start_req,
  input  logic                  in_cap_pin,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_cap_pos_drive,
  output logic                  out_cap_pos_high,
  output logic                  out_cap_neg_drive,
  output logic                  out_cap_neg_high,
  output logic                  out_probe_drive,
  output logic                  out_probe_high,
  output logic                  out_busy_res,
  output logic                  out_done_res,
  output logic [READ_W-1:0]     out_reading,
  output logic                  out_failed,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg_r;
  logic in_valid_r;
  logic in_start_r;
  logic in_pin_r;
  logic out_valid_r;
  res_t res;
  res_t out_res_r;
  logic advance;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.oversample_rate <= RATE_W'(6);
      cfg_r.charge_ticks    <= LIM_W'(1000);
      cfg_r.discharge_ticks <= LIM_W'(1000);
      cfg_r.timeout_ticks   <= LIM_W'(65535);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RATE:      cfg_r.oversample_rate <= cfg_wdata[RATE_W-1:0];
        REG_CHARGE:    cfg_r.charge_ticks    <= cfg_wdata[LIM_W-1:0];
        REG_DISCHARGE: cfg_r.discharge_ticks <= cfg_wdata[LIM_W-1:0];
        REG_TIMEOUT:   cfg_r.timeout_ticks   <= cfg_wdata[LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_start_r <= in_start_req;
      in_pin_r   <= in_cap_pin;
    end
  end

  cct_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .start (in_start_r),
    .pin   (in_pin_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cap_pos_drive = out_res_r.pins.pos_drive;
  assign out_cap_pos_high  = out_res_r.pins.pos_high;
  assign out_cap_neg_drive = out_res_r.pins.neg_drive;
  assign out_cap_neg_high  = out_res_r.pins.neg_high;
  assign out_probe_drive   = out_res_r.pins.probe_drive;
  assign out_probe_high    = out_res_r.pins.probe_high;
  assign out_busy_res      = out_res_r.busy;
  assign out_done_res      = out_res_r.done;
  assign out_reading       = out_res_r.reading;
  assign out_failed        = out_res_r.failed;

endmodule

/* sv/cct_checker.sv */
// Port-level checker for the capacitive conductivity timer, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module cct_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_cap_pos_drive,
  input logic        out_cap_neg_drive,
  input logic        out_probe_drive,
  input logic        out_busy_res,
  input logic        out_done_res,
  input logic [15:0] out_reading,
  input logic        out_failed
);

  `CCT_ASSERT_NEXT(a_out_valid_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `CCT_ASSERT_NEXT(a_out_reading_hold, clk, rst_n, out_valid && out_stall, $stable(out_reading))
  `CCT_ASSERT_NOW(a_done_not_busy, clk, rst_n, out_valid && out_done_res, !out_busy_res)
  `CCT_ASSERT_NOW(a_idle_released, clk, rst_n, out_valid && !out_busy_res, !out_cap_pos_drive && !out_cap_neg_drive && !out_probe_drive)
  `CCT_ASSERT_NOW(a_fail_zero, clk, rst_n, out_valid && out_done_res && out_failed, out_reading == 16'd0)

endmodule

bind capacitive_conductivity_timer cct_checker u_cct_checker (.*);

/* dv/capacitive_conductivity_timer_checker.sv */
`timescale 1ns / 1ps
// Checker for the capacitive conductivity timer: predicts pin drive, status and
// reading for every accepted tick and compares them with each result transaction.
// Depends on cct_pkg; instantiated by capacitive_conductivity_timer_tb.
module capacitive_conductivity_timer_checker
  import cct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  in_start_req,
  input  logic                  in_cap_pin,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  out_cap_pos_drive,
  input  logic                  out_cap_pos_high,
  input  logic                  out_cap_neg_drive,
  input  logic                  out_cap_neg_high,
  input  logic                  out_probe_drive,
  input  logic                  out_probe_high,
  input  logic                  out_busy_res,
  input  logic                  out_done_res,
  input  logic [READ_W-1:0]     out_reading,
  input  logic                  out_failed,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending,
  output logic                  meter_busy,
  output int                    readings_done,
  output int                    readings_failed
);

  cfg_t                  regs;
  stage_t                stage;
  logic [TIMER_BITS-1:0] stage_count;
  logic [CYC_BITS-1:0]   cycles_run;
  logic [ACC_BITS-1:0]   total_count;
  logic [TIMER_BITS-1:0] measured;
  logic                  pin_prev;
  logic [READ_W-1:0]     held_reading;
  logic                  held_fail;
  res_t                  expected_readouts[$];
  int                    mismatches = 0;
  int                    readout_idx = 0;
  int                    readings_seen = 0;
  int                    timeouts_seen = 0;

  assign fail_count      = mismatches;
  assign readings_done   = readings_seen;
  assign readings_failed = timeouts_seen;

  task automatic report_mismatch(string msg);
    $display("%0t checker: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [READ_W-1:0] got, logic [READ_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("readout %0d %s: got %0h, expected %0h",
                                readout_idx, name, got, want));
    end
  endtask

  task automatic check_bit(string name, logic got, logic want);
    if (got !== want) begin
      report_mismatch($sformatf("readout %0d %s: got %0b, expected %0b",
                                readout_idx, name, got, want));
    end
  endtask

  function automatic void enter_stage(stage_t s);
    stage       = s;
    stage_count = '0;
  endfunction

  // advance the stage counter; high when a stage with this limit is over
  function automatic logic tick_over(logic [LIM_W-1:0] limit);
    if (stage_count != TMAX) stage_count = stage_count + 1'b1;
    return (stage_count >= limit) || (stage_count == TMAX);
  endfunction

  function automatic res_t advance_meter(logic start, logic pin);
    res_t r;
    logic fired;
    logic timed_out;
    int   rate;
    fired = 1'b0;
    rate  = (regs.oversample_rate > MAX_RATE) ? MAX_RATE : int'(regs.oversample_rate);
    case (stage)
      ST_IDLE: begin
        if (start) begin
          cycles_run  = '0;
          total_count = '0;
          enter_stage(ST_CHARGE_POS);
        end
      end
      ST_CHARGE_POS: begin
        if (tick_over(regs.charge_ticks)) enter_stage(ST_MEASURE);
      end
      ST_MEASURE: begin
        timed_out = tick_over(regs.timeout_ticks);
        if (pin_prev && !pin) begin
          measured    = stage_count;
          total_count = total_count + ACC_BITS'(stage_count);
          enter_stage(ST_DISCHARGE);
        end else if (timed_out) begin
          held_reading = '0;
          held_fail    = 1'b1;
          fired        = 1'b1;
          enter_stage(ST_IDLE);
        end
      end
      ST_DISCHARGE: begin
        if (tick_over(regs.discharge_ticks)) enter_stage(ST_CHARGE_NEG);
      end
      ST_CHARGE_NEG: begin
        if (tick_over(regs.charge_ticks)) enter_stage(ST_COMPENSATE);
      end
      ST_COMPENSATE: begin
        if (tick_over(measured)) enter_stage(ST_RECHARGE);
      end
      ST_RECHARGE: begin
        if (tick_over(regs.discharge_ticks)) begin
          cycles_run = cycles_run + 1'b1;
          if (int'(cycles_run) >= (1 << rate)) begin
            held_reading = READ_W'(total_count >> rate);
            held_fail    = 1'b0;
            fired        = 1'b1;
            enter_stage(ST_IDLE);
          end else begin
            enter_stage(ST_CHARGE_POS);
          end
        end
      end
      default: begin
        enter_stage(ST_IDLE);
      end
    endcase
    pin_prev = pin;

    // pos drive/high, neg drive/high, probe drive/high
    case (stage)
      ST_CHARGE_POS: r.pins = 6'b111000;
      ST_MEASURE:    r.pins = 6'b001010;
      ST_DISCHARGE:  r.pins = 6'b101000;
      ST_CHARGE_NEG: r.pins = 6'b101100;
      ST_COMPENSATE: r.pins = 6'b001111;
      ST_RECHARGE:   r.pins = 6'b111100;
      default:       r.pins = 6'b000000;
    endcase
    r.busy    = (stage != ST_IDLE);
    r.done    = fired;
    r.reading = held_reading;
    r.failed  = held_fail;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      regs.oversample_rate = 4'd6;
      regs.charge_ticks    = 16'd1000;
      regs.discharge_ticks = 16'd1000;
      regs.timeout_ticks   = 16'hFFFF;
      stage                = ST_IDLE;
      stage_count          = '0;
      cycles_run           = '0;
      total_count          = '0;
      measured             = '0;
      pin_prev             = 1'b0;
      held_reading         = '0;
      held_fail            = 1'b0;
      expected_readouts.delete();
    end else begin
      if (out_valid && !out_stall) begin
        readout_idx++;
        if (expected_readouts.size() == 0) begin
          report_mismatch($sformatf("readout %0d came with no tick outstanding", readout_idx));
        end else begin
          want = expected_readouts.pop_front();
          check_bit("cap_pos_drive", out_cap_pos_drive, want.pins.pos_drive);
          check_bit("cap_pos_high", out_cap_pos_high, want.pins.pos_high);
          check_bit("cap_neg_drive", out_cap_neg_drive, want.pins.neg_drive);
          check_bit("cap_neg_high", out_cap_neg_high, want.pins.neg_high);
          check_bit("probe_drive", out_probe_drive, want.pins.probe_drive);
          check_bit("probe_high", out_probe_high, want.pins.probe_high);
          check_bit("busy_res", out_busy_res, want.busy);
          check_bit("done_res", out_done_res, want.done);
          check_field("reading", out_reading, want.reading);
          check_bit("failed", out_failed, want.failed);
          if (want.done) begin
            readings_seen++;
            if (want.failed) timeouts_seen++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_RATE:      regs.oversample_rate = cfg_wdata[RATE_W-1:0];
          REG_CHARGE:    regs.charge_ticks    = cfg_wdata[LIM_W-1:0];
          REG_DISCHARGE: regs.discharge_ticks = cfg_wdata[LIM_W-1:0];
          REG_TIMEOUT:   regs.timeout_ticks   = cfg_wdata[LIM_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        expected_readouts.push_back(advance_meter(in_start_req, in_cap_pin));
      end
    end
    pending    <= expected_readouts.size();
    meter_busy <= (stage != ST_IDLE);
  end

endmodule

/* dv/capacitive_conductivity_timer_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the capacitive conductivity timer: drives reset, ticks and
// register writes and gives the verdict. Depends on cct_pkg, the block and
// capacitive_conductivity_timer_checker.
module capacitive_conductivity_timer_tb;
  import cct_pkg::*;

  localparam int CLK_HALF_NS   = 6;
  localparam int RESET_CYCLES  = 11;
  localparam int LIMIT_CYCLES  = 400_000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_TICKS   = 75;
  localparam int TAIL_CYCLES   = 10;

  typedef enum logic [1:0] {PIN_WALK, PIN_TOGGLE, PIN_HIGH} pin_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_start_req;
  logic                  in_cap_pin;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_cap_pos_drive;
  logic                  out_cap_pos_high;
  logic                  out_cap_neg_drive;
  logic                  out_cap_neg_high;
  logic                  out_probe_drive;
  logic                  out_probe_high;
  logic                  out_busy_res;
  logic                  out_done_res;
  logic [READ_W-1:0]     out_reading;
  logic                  out_failed;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int        fail_count;
  int        pending;
  logic      meter_busy;
  int        readings_done;
  int        readings_failed;

  bit        idle_en = 1'b0;
  pin_mode_t pin_mode = PIN_TOGGLE;
  logic      pin_level = 1'b0;
  int        run_left = 0;
  int        walk_max = 4;
  int        ticks_sent = 0;
  int        settings_used = 0;

  capacitive_conductivity_timer DUT (.*);

  capacitive_conductivity_timer_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #CLK_HALF_NS;
    clk = 1'b1;
    #CLK_HALF_NS;
  end

  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF_NS);
    $display("** capacitive_conductivity_timer: FAILED **");
    $finish;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (idle_en && $urandom_range(0, 11) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic next_pin();
    case (pin_mode)
      PIN_HIGH:   pin_level = 1'b1;
      PIN_TOGGLE: pin_level = ~pin_level;
      default: begin
        if (run_left == 0) begin
          pin_level = ~pin_level;
          run_left  = $urandom_range(1, walk_max);
        end
        run_left--;
      end
    endcase
    return pin_level;
  endfunction

  task automatic send_tick(logic start, logic pin);
    if (idle_en && $urandom_range(0, 11) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_start_req <= start;
    in_cap_pin   <= pin;
    do @(posedge clk); while (in_stall);
    ticks_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(int rate, int charge, int discharge, int timeout);
    write_reg(REG_RATE, CFG_DATA_W'(rate));
    write_reg(REG_CHARGE, CFG_DATA_W'(charge));
    write_reg(REG_DISCHARGE, CFG_DATA_W'(discharge));
    write_reg(REG_TIMEOUT, CFG_DATA_W'(timeout));
    write_reg(CFG_IDX_W'($urandom_range(int'(REG_TIMEOUT) + 1, (1 << CFG_IDX_W) - 1)),
              CFG_DATA_W'($urandom));
    settings_used++;
  endtask

  // tick on with no start until the reading ends, then hold until drained
  task automatic settle();
    do send_tick(1'b0, next_pin()); while (meter_busy);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_start_req = 1'b0;
    in_cap_pin   = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    settle();

    configure(0, 0, 0, 0);
    send_tick(1'b1, next_pin());
    settle();

    // edge on the timeout tick
    configure(0, 1, 1, 1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    settle();
    pin_mode = PIN_HIGH;
    send_tick(1'b1, next_pin());
    settle();

    // rate above the maximum; repeated starts across timed-out readings
    configure(15, 1, 1, 4);
    repeat (20) send_tick(1'b1, next_pin());
    settle();

    // starts during the reading are dropped
    configure(2, 1, 1, 16'hFFFF);
    pin_mode = PIN_WALK;
    walk_max = 3;
    repeat (20) send_tick(1'b1, next_pin());
    settle();

    configure(0, 40, 3, 60);
    pin_mode = PIN_HIGH;
    send_tick(1'b1, next_pin());
    settle();

    configure(1, 2, 2, 16'hFFFF);
    pin_mode = PIN_WALK;
    walk_max = 20;
    send_tick(1'b1, next_pin());
    settle();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      idle_en = (phase == RANDOM_PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      configure($urandom_range(0, 3), $urandom_range(0, 4), $urandom_range(0, 4),
                $urandom_range(0, 24));
      pin_mode = PIN_WALK;
      walk_max = $urandom_range(1, 12);
      repeat (PHASE_TICKS) send_tick($urandom_range(0, 3) == 0, next_pin());
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("capacitive_conductivity_timer: %0d ticks under %0d register settings",
             ticks_sent, settings_used);
    $display("capacitive_conductivity_timer: %0d readings finished, %0d on timeout",
             readings_done, readings_failed);
    if (fail_count == 0 && pending == 0) begin
      $display("** capacitive_conductivity_timer: PASSED **");
    end else begin
      $display("** capacitive_conductivity_timer: FAILED **");
    end
    $finish;
  end

endmodule
